// ----- src/bpdm_pkg.sv -----
`default_nettype none

package bpdm_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int ANGLE_FRAC    = 8;
	localparam int TURN_FRAC     = 12;

	// scaling of the pd increment onto the accumulator grid
	localparam int UP   = (FRACTION_BITS >= ANGLE_FRAC) ? FRACTION_BITS - ANGLE_FRAC : 0;
	localparam int DOWN = (FRACTION_BITS <  ANGLE_FRAC) ? ANGLE_FRAC - FRACTION_BITS : 0;

	localparam int PD_W    = 37;
	localparam int T_W     = PD_W + UP;
	localparam int ACC_W   = 16 + FRACTION_BITS;
	localparam int ACC_S_W = T_W + 1;

	localparam int TPROD_W = 26;
	localparam int TURN_W  = TPROD_W - TURN_FRAC;
	localparam int WHEEL_W = 15;
	localparam int MIX_W   = 18;
	localparam int WHEEL_LIM = 16383;

	typedef enum logic [1:0] {
		MODE_STOP    = 2'd0,
		MODE_FORWARD = 2'd1,
		MODE_LEFT    = 2'd2,
		MODE_RIGHT   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_PROP_GAIN     = 3'd0,
		REG_DERIV_GAIN    = 3'd1,
		REG_TURN_GAIN     = 3'd2,
		REG_FORWARD_LEAN  = 3'd3,
		REG_TURN_TARGET   = 3'd4,
		REG_LEFT_OFFSET   = 3'd5,
		REG_SPEED_LIMIT   = 3'd6,
		REG_SP_STEP_LIMIT = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  prop_gain;
		logic [15:0] deriv_gain_per_dt;
		logic [7:0]  turn_gain;
		logic [15:0] forward_lean_setpoint;
		logic [15:0] turn_rate_target;
		logic [13:0] left_turn_offset;
		logic [13:0] speed_limit;
		logic [14:0] setpoint_step_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		prop_gain:             8'd20,
		deriv_gain_per_dt:     16'd2600,
		turn_gain:             8'd26,
		forward_lean_setpoint: 16'hFB00,
		turn_rate_target:      16'd9600,
		left_turn_offset:      14'd500,
		speed_limit:           14'd10000,
		setpoint_step_limit:   15'd2048
	};

endpackage

`default_nettype wire

// ----- src/bpdm_pd.sv -----
`default_nettype none

module bpdm_pd
	import bpdm_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     step,
	input  wire mode_t                    func,
	input  wire logic signed [16:0]       angle_y,
	input  wire logic signed [15:0]       gyro_z,
	input  wire cfg_t                     cfg,
	output      logic signed [T_W-1:0]    pd_incr,
	output      logic signed [TURN_W-1:0] turn
);

	logic signed [16:0]        prev_angle_q;
	logic signed [15:0]        prev_sp_q;
	logic signed [15:0]        sp;
	logic signed [16:0]        dsp_raw;
	logic signed [16:0]        lim;
	logic signed [16:0]        dsp;
	logic signed [17:0]        err;
	logic signed [17:0]        dang;
	logic signed [18:0]        dterm;
	logic signed [26:0]        pprod;
	logic signed [35:0]        dprod;
	logic signed [PD_W-1:0]    pd_sum;
	logic signed [T_W-1:0]     t_ext;
	logic signed [16:0]        tdiff;
	logic signed [TPROD_W-1:0] tprod;

	always_comb begin
		sp = (func == MODE_FORWARD) ? $signed(cfg.forward_lean_setpoint) : 16'sd0;
		dsp_raw = 17'(sp) - 17'(prev_sp_q);
		lim = $signed({2'b00, cfg.setpoint_step_limit});
		// setpoint change limited to the step bound
		if (dsp_raw > lim) begin
			dsp = lim;
		end else if (dsp_raw < -lim) begin
			dsp = -lim;
		end else begin
			dsp = dsp_raw;
		end
		err   = 18'(sp) - 18'(angle_y);
		dang  = 18'(angle_y) - 18'(prev_angle_q);
		dterm = 19'(dsp) - 19'(dang);
		pprod = $signed({1'b0, cfg.prop_gain}) * err;
		dprod = $signed({1'b0, cfg.deriv_gain_per_dt}) * dterm;
		pd_sum = PD_W'(pprod) + PD_W'(dprod);
		t_ext = T_W'(pd_sum);
		pd_incr = (t_ext <<< UP) >>> DOWN;

		tdiff = 17'($signed(cfg.turn_rate_target)) - 17'(gyro_z);
		tprod = $signed({1'b0, cfg.turn_gain}) * tdiff;
		turn  = tprod[TPROD_W-1:TURN_FRAC];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_angle_q <= '0;
			prev_sp_q    <= '0;
		end else if (step) begin
			prev_angle_q <= angle_y;
			prev_sp_q    <= sp;
		end
	end

endmodule

`default_nettype wire

// ----- src/balance_pd_drive_mixer_core.sv -----
`default_nettype none

// Balance controller for a two-wheel robot: PD on tilt plus a wheel mixer.
// Input beats (s_*): tdata holds angle_y and gyro_z, tuser holds the motion
// mode. Each input beat yields exactly one output beat (m_*) carrying both
// wheel speeds and the drive level.
// A beat moves from the input register through the PD and accumulator stage
// registers into the output register that drives m_tvalid. Throughput: one
// beat per cycle while no stage is held up by a low m_tready.
// Stages: input register, PD and turn products, accumulator add and clamp,
// wheel mix into the output register.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata and
// must only change while no beat is in flight.
// Reset clears the accumulator, the previous angle and setpoint, all valid
// bits, and loads the default gains and limits.
// When m_tready is low, the output register holds its beat; bubbles further
// up still close up, and s_tready falls only once every stage is occupied.

module balance_pd_drive_mixer_core
	import bpdm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [39:0] s_tdata,   // angle_y[16:0], gyro_z[32:17], zero pad
	input  wire logic [1:0]  s_tuser,   // func[1:0]
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [47:0] m_tdata    // motor_a_speed[14:0], motor_b_speed[29:15],
	                                    // drive_level[44:30], zero pad
);

	cfg_t cfg_q;

	logic v1_q, v2_q, v3_q, ov_q;
	logic r1, r2, r3, r_out;
	logic mv1, mv2, mv3;

	mode_t                    func_s1, func_s2, func_s3;
	logic signed [16:0]       angle_s1;
	logic signed [15:0]       gyro_s1;
	logic signed [T_W-1:0]    pd_incr;
	logic signed [TURN_W-1:0] turn;
	logic signed [T_W-1:0]    incr_s2;
	logic signed [TURN_W-1:0] turn_s2, turn_s3;
	logic signed [ACC_W-1:0]  acc_q, acc_next;
	logic signed [ACC_S_W-1:0] acc_sum, acc_lim;
	logic signed [WHEEL_W-1:0] level_s3;
	logic signed [MIX_W-1:0]  neg, off_ext, turn_ext, mix_a, mix_b;
	logic [WHEEL_W-1:0]       mota_q, motb_q, level_q;

	function automatic logic [WHEEL_W-1:0] wheel_sat(input logic signed [MIX_W-1:0] v);
		logic signed [MIX_W-1:0] r;
		r = v;
		if (v > MIX_W'(WHEEL_LIM)) begin
			r = MIX_W'(WHEEL_LIM);
		end else if (v < -MIX_W'(WHEEL_LIM)) begin
			r = -MIX_W'(WHEEL_LIM);
		end
		return r[WHEEL_W-1:0];
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_PROP_GAIN:     cfg_q.prop_gain             <= cfg_wdata[7:0];
				REG_DERIV_GAIN:    cfg_q.deriv_gain_per_dt     <= cfg_wdata;
				REG_TURN_GAIN:     cfg_q.turn_gain             <= cfg_wdata[7:0];
				REG_FORWARD_LEAN:  cfg_q.forward_lean_setpoint <= cfg_wdata;
				REG_TURN_TARGET:   cfg_q.turn_rate_target      <= cfg_wdata;
				REG_LEFT_OFFSET:   cfg_q.left_turn_offset      <= cfg_wdata[13:0];
				REG_SPEED_LIMIT:   cfg_q.speed_limit           <= cfg_wdata[13:0];
				REG_SP_STEP_LIMIT: cfg_q.setpoint_step_limit   <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// stage flow control, each stage moves when the next one frees up
	assign r_out    = !ov_q || m_tready;
	assign r3       = !v3_q || r_out;
	assign r2       = !v2_q || r3;
	assign r1       = !v1_q || r2;
	assign mv1      = v1_q && r2;
	assign mv2      = v2_q && r3;
	assign mv3      = v3_q && r_out;
	assign s_tready = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (r1) begin
				v1_q <= s_tvalid;
			end
			if (r2) begin
				v2_q <= v1_q;
			end
			if (r3) begin
				v3_q <= v2_q;
			end
			if (r_out) begin
				ov_q <= v3_q;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (s_tvalid && r1) begin
			func_s1  <= mode_t'(s_tuser[1:0]);
			angle_s1 <= $signed(s_tdata[16:0]);
			gyro_s1  <= $signed(s_tdata[32:17]);
		end
	end

	bpdm_pd u_pd (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (mv1),
		.func    (func_s1),
		.angle_y (angle_s1),
		.gyro_z  (gyro_s1),
		.cfg     (cfg_q),
		.pd_incr (pd_incr),
		.turn    (turn)
	);

	always_ff @(posedge clk) begin
		if (mv1) begin
			incr_s2 <= pd_incr;
			turn_s2 <= turn;
			func_s2 <= func_s1;
		end
	end

	// drive accumulator, saturating at the speed limit
	always_comb begin
		acc_sum = ACC_S_W'(acc_q) + ACC_S_W'(incr_s2);
		acc_lim = ACC_S_W'($signed({2'b00, cfg_q.speed_limit, {FRACTION_BITS{1'b0}}}));
		if (acc_sum > acc_lim) begin
			acc_next = ACC_W'(acc_lim);
		end else if (acc_sum < -acc_lim) begin
			acc_next = ACC_W'(-acc_lim);
		end else begin
			acc_next = ACC_W'(acc_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (mv2) begin
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (mv2) begin
			level_s3 <= acc_next[FRACTION_BITS+WHEEL_W-1:FRACTION_BITS];
			turn_s3  <= turn_s2;
			func_s3  <= func_s2;
		end
	end

	// wheel mix
	always_comb begin
		neg      = -MIX_W'(level_s3);
		off_ext  = $signed(MIX_W'({1'b0, cfg_q.left_turn_offset}));
		turn_ext = MIX_W'(turn_s3);
		case (func_s3)
			MODE_LEFT: begin
				mix_a = neg + off_ext;
				mix_b = neg - off_ext;
			end
			MODE_RIGHT: begin
				mix_a = neg - turn_ext;
				mix_b = neg + turn_ext;
			end
			default: begin
				mix_a = neg;
				mix_b = neg;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mv3) begin
			mota_q  <= wheel_sat(mix_a);
			motb_q  <= wheel_sat(mix_b);
			level_q <= level_s3;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {3'b000, level_q, motb_q, mota_q};

`ifndef SYNTHESIS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v1_q && v2_q && v3_q && ov_q))
		else $error("input stalled with a free stage");

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!mv2 |=> $stable(acc_q))
		else $error("accumulator moved without a beat");

	a_wheel_range: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (mota_q != 15'h4000 && motb_q != 15'h4000 && level_q != 15'h4000))
		else $error("output outside saturation range");
`endif

endmodule

`default_nettype wire
